// ===== rtl/pnda_pkg.sv =====
// Shared constants, the arctangent table and the CORDIC sideband type for the
// plane normal to dip and azimuth pipeline. No dependencies.
package pnda_pkg;

  // Width of one normal component and number of CORDIC micro-rotations.
  localparam int COMPONENT_WIDTH = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int TABLE_LEN       = 24;
  localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // Components are scaled by 2^PRESCALE; four guard bits cover CORDIC growth.
  localparam int PRESCALE = 24;
  localparam int DW       = COMPONENT_WIDTH + PRESCALE + 4;

  // Vectoring gain in Q30 and the width of the scaled |z|.
  localparam int GAIN_W = 31;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195364;
  localparam int GAIN_SHIFT = 30 - PRESCALE;
  localparam int ZS_W = COMPONENT_WIDTH + GAIN_W - GAIN_SHIFT;

  // Angle accumulators: hundredths of a degree in Q16, signed.
  localparam int AW = 33;
  localparam logic signed [AW-1:0] FULL_Q16  = 33'sd2359296000;
  localparam logic signed [AW-1:0] HALF_Q16  = 33'sd1179648000;
  localparam logic signed [AW-1:0] RIGHT_Q16 = 33'sd589824000;
  localparam logic signed [AW-1:0] ROUND_Q16 = 33'sd32768;

  localparam int DIR_W = 16;
  localparam int DIP_W = 14;
  localparam int RND_W = AW - 16;
  localparam logic [RND_W-1:0] DIR_WRAP = 17'd36000;

  typedef struct packed {
    logic          undef;
    logic [DW-1:0] aux;
  } side_t;

  // atan(2^-idx) in hundredths of a degree, Q16, rounded to nearest.
  function automatic logic signed [AW-1:0] atan_q16(input int unsigned idx);
    logic signed [AW-1:0] v;
    case (idx)
      0:  v = 33'sd294912000;
      1:  v = 33'sd174096719;
      2:  v = 33'sd91987925;
      3:  v = 33'sd46694507;
      4:  v = 33'sd23437865;
      5:  v = 33'sd11730358;
      6:  v = 33'sd5866610;
      7:  v = 33'sd2933484;
      8:  v = 33'sd1466764;
      9:  v = 33'sd733385;
      10: v = 33'sd366693;
      11: v = 33'sd183346;
      12: v = 33'sd91673;
      13: v = 33'sd45837;
      14: v = 33'sd22918;
      15: v = 33'sd11459;
      16: v = 33'sd5730;
      17: v = 33'sd2865;
      18: v = 33'sd1432;
      19: v = 33'sd716;
      20: v = 33'sd358;
      21: v = 33'sd179;
      22: v = 33'sd90;
      23: v = 33'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/plane_normal_to_dip_and_azimuth.sv =====
// From start to out_valid an item passes the prep stages, both CORDIC chains and the finish stages.
// Throughput: one item per clock; every stage is a register stage, so busy stays low.
// The depth is set mostly by the two vectoring CORDIC chains, one micro-rotation per stage.
// Reset (rst_n low, synchronous) clears all valid bits; items in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
module plane_normal_to_dip_and_azimuth (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  output logic                                        busy,
  input  logic signed [pnda_pkg::COMPONENT_WIDTH-1:0] in_normal_x,
  input  logic signed [pnda_pkg::COMPONENT_WIDTH-1:0] in_normal_y,
  input  logic signed [pnda_pkg::COMPONENT_WIDTH-1:0] in_normal_z,
  output logic                                        out_valid,
  output logic [pnda_pkg::DIR_W-1:0]                  out_dip_direction,
  output logic [pnda_pkg::DIP_W-1:0]                  out_dip_angle,
  output logic                                        out_undefined_direction
);

  // Total number of register stages between start and out_valid.
  localparam int LATENCY = 2 * pnda_pkg::NSTEPS + 4;

  logic                           p_valid;
  logic signed [pnda_pkg::DW-1:0] p_cx, p_cy;
  logic signed [pnda_pkg::AW-1:0] p_acc;
  pnda_pkg::side_t                p_side;

  logic                           a_valid;
  logic signed [pnda_pkg::DW-1:0] a_x;
  logic signed [pnda_pkg::AW-1:0] a_acc;
  pnda_pkg::side_t                a_side;

  logic                           d_valid;
  logic signed [pnda_pkg::DW-1:0] d_x;
  logic signed [pnda_pkg::AW-1:0] d_acc;
  pnda_pkg::side_t                d_side;

  logic                           b_x_unused;

  logic signed [pnda_pkg::DW-1:0] zs_ext;
  pnda_pkg::side_t                d_side_in;

  // The pipeline takes an item in every cycle.
  assign busy = 1'b0;

  // Prescale the components and fold x < 0 onto the right half-plane; the
  // fold adds half a turn to the azimuth accumulator up front.
  pnda_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_x      (in_normal_x),
    .in_y      (in_normal_y),
    .in_z      (in_normal_z),
    .out_valid (p_valid),
    .out_cx    (p_cx),
    .out_cy    (p_cy),
    .out_acc   (p_acc),
    .out_side  (p_side)
  );

  // First CORDIC: azimuth of (x, -y). Its final x is the gain-scaled
  // horizontal magnitude, which feeds the dip-angle rotation directly.
  pnda_cordic u_cordic_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_x      (p_cx),
    .in_y      (p_cy),
    .in_acc    (p_acc),
    .in_side   (p_side),
    .out_valid (a_valid),
    .out_x     (a_x),
    .out_acc   (a_acc),
    .out_side  (a_side)
  );

  // The gain-scaled |z| rode along in the sideband; the azimuth accumulator
  // takes its place for the second chain.
  assign zs_ext          = a_side.aux;
  assign d_side_in.undef = a_side.undef;
  assign d_side_in.aux   = {{(pnda_pkg::DW-pnda_pkg::AW){a_acc[pnda_pkg::AW-1]}}, a_acc};

  // Second CORDIC: dip angle = atan2(h, |z|).
  pnda_cordic u_cordic_dip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_x      (zs_ext),
    .in_y      (a_x),
    .in_acc    ('0),
    .in_side   (d_side_in),
    .out_valid (d_valid),
    .out_x     (d_x),
    .out_acc   (d_acc),
    .out_side  (d_side)
  );

  // The final magnitude of the dip rotation is not needed.
  assign b_x_unused = ^d_x;

  pnda_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d_valid),
    .in_dir_acc (d_side.aux[pnda_pkg::AW-1:0]),
    .in_dip_acc (d_acc),
    .in_undef   (d_side.undef),
    .out_valid  (out_valid),
    .out_dir    (out_dip_direction),
    .out_dip    (out_dip_angle),
    .out_undef  (out_undefined_direction)
  );

  // Every result traces back to an earlier item taken at start.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a matching item");

  a_dir_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dip_direction < 16'd36000) && (out_dip_angle <= 14'd9000))
    else $error("angle out of range");

  a_undef_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_undefined_direction) |->
      (out_dip_direction == '0) && (out_dip_angle == '0))
    else $error("undefined direction with nonzero angles");

  a_undef_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_undefined_direction) |->
      ($past(in_normal_x, LATENCY) == '0) && ($past(in_normal_y, LATENCY) == '0))
    else $error("undefined flag on a tilted normal");

endmodule

// ===== rtl/pnda_prep.sv =====
// Front end of the pipeline: prescaling, half-plane fold and the |z| gain
// multiply, in two register stages. Depends on pnda_pkg.
module pnda_prep (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  logic signed [pnda_pkg::COMPONENT_WIDTH-1:0]   in_x,
  input  logic signed [pnda_pkg::COMPONENT_WIDTH-1:0]   in_y,
  input  logic signed [pnda_pkg::COMPONENT_WIDTH-1:0]   in_z,
  output logic                                          out_valid,
  output logic signed [pnda_pkg::DW-1:0]                out_cx,
  output logic signed [pnda_pkg::DW-1:0]                out_cy,
  output logic signed [pnda_pkg::AW-1:0]                out_acc,
  output pnda_pkg::side_t                               out_side
);

  localparam int CW  = pnda_pkg::COMPONENT_WIDTH;
  localparam int DW  = pnda_pkg::DW;
  localparam int EXT = DW - CW - pnda_pkg::PRESCALE;

  logic signed [DW-1:0] xs, ys, xn, yn;
  logic signed [CW:0]   z_ext, z_neg;
  logic [CW-1:0]        z_abs;

  logic                 v1_r, v2_r;
  logic signed [DW-1:0] cx1_r, cy1_r, cx2_r, cy2_r;
  logic                 neg1_r, undef1_r, undef2_r;
  logic [CW-1:0]        zabs1_r;
  logic signed [pnda_pkg::AW-1:0] acc2_r;
  logic [CW+pnda_pkg::GAIN_W-1:0] prod;
  logic [pnda_pkg::ZS_W-1:0]      zs2_r;

  assign xs    = {{EXT{in_x[CW-1]}}, in_x, {pnda_pkg::PRESCALE{1'b0}}};
  assign ys    = {{EXT{in_y[CW-1]}}, in_y, {pnda_pkg::PRESCALE{1'b0}}};
  assign xn    = -xs;
  assign yn    = -ys;
  assign z_ext = {in_z[CW-1], in_z};
  assign z_neg = -z_ext;
  assign z_abs = in_z[CW-1] ? z_neg[CW-1:0] : in_z;

  // Stage one: fold the left half-plane onto the right one (atan2(-y, x)).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cx1_r    <= in_x[CW-1] ? xn : xs;
    cy1_r    <= in_x[CW-1] ? ys : yn;
    neg1_r   <= in_x[CW-1];
    undef1_r <= (in_x == '0) && (in_y == '0);
    zabs1_r  <= z_abs;
  end

  // Stage two: scale |z| by the CORDIC gain for the dip-angle rotation.
  assign prod = zabs1_r * pnda_pkg::GAIN_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cx2_r    <= cx1_r;
    cy2_r    <= cy1_r;
    acc2_r   <= neg1_r ? pnda_pkg::HALF_Q16 : '0;
    undef2_r <= undef1_r;
    zs2_r    <= prod[CW+pnda_pkg::GAIN_W-1:pnda_pkg::GAIN_SHIFT];
  end

  assign out_valid      = v2_r;
  assign out_cx         = cx2_r;
  assign out_cy         = cy2_r;
  assign out_acc        = acc2_r;
  assign out_side.undef = undef2_r;
  assign out_side.aux   = {{(DW-pnda_pkg::ZS_W){1'b0}}, zs2_r};

endmodule

// ===== rtl/pnda_cordic.sv =====
// Pipelined vectoring CORDIC, one register stage per micro-rotation, with a
// sideband that travels alongside. Depends on pnda_pkg.
module pnda_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic signed [pnda_pkg::DW-1:0] in_x,
  input  logic signed [pnda_pkg::DW-1:0] in_y,
  input  logic signed [pnda_pkg::AW-1:0] in_acc,
  input  pnda_pkg::side_t                in_side,
  output logic                           out_valid,
  output logic signed [pnda_pkg::DW-1:0] out_x,
  output logic signed [pnda_pkg::AW-1:0] out_acc,
  output pnda_pkg::side_t                out_side
);

  localparam int N  = pnda_pkg::NSTEPS;
  localparam int DW = pnda_pkg::DW;
  localparam int AW = pnda_pkg::AW;

  logic                 v_r   [0:N-1];
  logic signed [DW-1:0] x_r   [0:N-1];
  logic signed [DW-1:0] y_r   [0:N-1];
  logic signed [AW-1:0] acc_r [0:N-1];
  pnda_pkg::side_t      s_r   [0:N-1];
  logic signed [DW-1:0] x_nxt [0:N-1];
  logic signed [DW-1:0] y_nxt [0:N-1];
  logic signed [AW-1:0] acc_nxt [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                 vi;
    logic signed [DW-1:0] xi, yi, dx, dy;
    logic signed [AW-1:0] ai;
    pnda_pkg::side_t      si;
    logic                 pos;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_x;
      assign yi = in_y;
      assign ai = in_acc;
      assign si = in_side;
    end else begin : g_next
      assign vi = v_r[i-1];
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign ai = acc_r[i-1];
      assign si = s_r[i-1];
    end

    assign dx  = yi >>> i;
    assign dy  = xi >>> i;
    assign pos = !yi[DW-1] && (yi != '0);

    // Rotate towards y = 0 and track the angle turned through.
    always_comb begin
      if (pos) begin
        x_nxt[i]   = xi + dx;
        y_nxt[i]   = yi - dy;
        acc_nxt[i] = ai + pnda_pkg::atan_q16(i);
      end else begin
        x_nxt[i]   = xi - dx;
        y_nxt[i]   = yi + dy;
        acc_nxt[i] = ai - pnda_pkg::atan_q16(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]   <= x_nxt[i];
      y_r[i]   <= y_nxt[i];
      acc_r[i] <= acc_nxt[i];
      s_r[i]   <= si;
    end
  end

  assign out_valid = v_r[N-1];
  assign out_x     = x_r[N-1];
  assign out_acc   = acc_r[N-1];
  assign out_side  = s_r[N-1];

endmodule

// ===== rtl/pnda_finish.sv =====
// Back end: wraps the azimuth, clamps the dip angle, rounds both to hundredths
// of a degree and holds the result registers. Depends on pnda_pkg.
module pnda_finish (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [pnda_pkg::AW-1:0]    in_dir_acc,
  input  logic signed [pnda_pkg::AW-1:0]    in_dip_acc,
  input  logic                              in_undef,
  output logic                              out_valid,
  output logic [pnda_pkg::DIR_W-1:0]        out_dir,
  output logic [pnda_pkg::DIP_W-1:0]        out_dip,
  output logic                              out_undef
);

  localparam int AW = pnda_pkg::AW;

  logic signed [AW-1:0] dir_add, dir_sub, dir_sum, dip_sum;
  logic [pnda_pkg::RND_W-1:0] dir_rnd, dir_fix;

  logic                 va_r, vb_r;
  logic signed [AW-1:0] dir_a_r, dip_a_r;
  logic                 undef_a_r, undef_b_r;
  logic [pnda_pkg::DIR_W-1:0] dir_b_r;
  logic [pnda_pkg::DIP_W-1:0] dip_b_r;

  assign dir_add = in_dir_acc + pnda_pkg::FULL_Q16;
  assign dir_sub = in_dir_acc - pnda_pkg::FULL_Q16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  // Stage A: bring the azimuth into one turn, clamp the dip between zero and a right angle.
  always_ff @(posedge clk) begin
    if (in_dir_acc < 0) begin
      dir_a_r <= dir_add;
    end else if (in_dir_acc >= pnda_pkg::FULL_Q16) begin
      dir_a_r <= dir_sub;
    end else begin
      dir_a_r <= in_dir_acc;
    end
    if (in_dip_acc < 0) begin
      dip_a_r <= '0;
    end else if (in_dip_acc > pnda_pkg::RIGHT_Q16) begin
      dip_a_r <= pnda_pkg::RIGHT_Q16;
    end else begin
      dip_a_r <= in_dip_acc;
    end
    undef_a_r <= in_undef;
  end

  // Stage B: round half up; a full turn after rounding reads as north; an undefined direction gives zeros.
  assign dir_sum = dir_a_r + pnda_pkg::ROUND_Q16;
  assign dip_sum = dip_a_r + pnda_pkg::ROUND_Q16;
  assign dir_rnd = dir_sum[AW-1:16];
  assign dir_fix = (dir_rnd >= pnda_pkg::DIR_WRAP) ? (dir_rnd - pnda_pkg::DIR_WRAP) : dir_rnd;

  always_ff @(posedge clk) begin
    dir_b_r   <= undef_a_r ? '0 : dir_fix[pnda_pkg::DIR_W-1:0];
    dip_b_r   <= undef_a_r ? '0 : dip_sum[pnda_pkg::DIP_W+15:16];
    undef_b_r <= undef_a_r;
  end

  assign out_valid = vb_r;
  assign out_dir   = dir_b_r;
  assign out_dip   = dip_b_r;
  assign out_undef = undef_b_r;

endmodule
